// File: hw/rtl/i2cm_pkg.sv
// package for the i2c register transfer master
// holds payload structs, config struct, phase enum and constants; no dependencies
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned MaxBytes = 8;
  localparam int unsigned DataW    = 8 * MaxBytes;
  localparam int unsigned CfgDataW = 16;

  localparam logic [3:0] MaxBytesCnt = 4'(MaxBytes);

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  localparam logic CfgIdxDevAddr    = 1'b0;
  localparam logic CfgIdxAckTimeout = 1'b1;

  localparam logic [6:0]  DevAddrReset    = 7'd50;
  localparam logic [15:0] AckTimeoutReset = 16'd1000;

  typedef enum logic [4:0] {
    PhIdle     = 5'd0,
    PhStartA   = 5'd1,
    PhStartB   = 5'd2,
    PhStartC   = 5'd3,
    PhBitLow   = 5'd4,
    PhBitHigh  = 5'd5,
    PhAckLow   = 5'd6,
    PhAckHigh  = 5'd7,
    PhAckPoll  = 5'd8,
    PhRdLow    = 5'd9,
    PhRdHigh   = 5'd10,
    PhRdSample = 5'd11,
    PhMackLow  = 5'd12,
    PhMackHigh = 5'd13,
    PhMackEnd  = 5'd14,
    PhStopA    = 5'd15,
    PhStopB    = 5'd16,
    PhStopC    = 5'd17
  } phase_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       reg_addr;
    logic [3:0]       byte_count;
    logic [DataW-1:0] write_data;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic             success;
    logic [DataW-1:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] ack_timeout;
  } cfg_t;

endpackage

// File: hw/rtl/i2cm_engine.sv
// bus sequencer: phase state, shift and count registers, one step per transfer
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cm_pkg::in_item_t  item_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::out_item_t res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [3:0] byte_idx_q, byte_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [15:0] wait_cnt_q, wait_cnt_d;
  logic read_mode_q, read_mode_d;
  logic ok_q, ok_d;
  logic [3:0] total_q, total_d;
  logic [i2cm_pkg::DataW-1:0] rd_buf_q, rd_buf_d;
  logic [i2cm_pkg::DataW-1:0] wr_buf_q, wr_buf_d;
  logic [7:0] target_q, target_d;

  logic [3:0] bit_inc;
  logic [3:0] byte_inc;
  logic [2:0] wr_k;
  logic [5:0] rd_pos;
  logic last_rd;
  logic write_done;
  logic timeout;
  logic [3:0] n_sat;
  logic [7:0] addr_byte;

  always_comb begin
    bit_inc    = bit_cnt_q + 4'd1;
    byte_inc   = byte_idx_q + 4'd1;
    wr_k       = 3'(byte_inc - 4'd2);
    rd_pos     = {byte_idx_q[2:0], 3'b000};
    last_rd    = ({1'b0, byte_idx_q} + 5'd1) >= {1'b0, total_q};
    write_done = {1'b0, byte_inc} >= ({1'b0, total_q} + 5'd2);
    timeout    = ({1'b0, wait_cnt_q} + 17'd1) >= {1'b0, cfg_i.ack_timeout};
    addr_byte  = {cfg_i.dev_addr, read_mode_q && (byte_idx_q == 4'd2)};
    if (item_i.byte_count == 4'd0) begin
      n_sat = 4'd1;
    end else if (item_i.byte_count > i2cm_pkg::MaxBytesCnt) begin
      n_sat = i2cm_pkg::MaxBytesCnt;
    end else begin
      n_sat = item_i.byte_count;
    end
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    byte_idx_d  = byte_idx_q;
    shift_d     = shift_q;
    wait_cnt_d  = wait_cnt_q;
    read_mode_d = read_mode_q;
    ok_d        = ok_q;
    total_d     = total_q;
    rd_buf_d    = rd_buf_q;
    wr_buf_d    = wr_buf_q;
    target_d    = target_q;
    unique case (phase_q)
      i2cm_pkg::PhIdle: begin
        if (item_i.cmd == i2cm_pkg::CmdWrite || item_i.cmd == i2cm_pkg::CmdRead) begin
          total_d     = n_sat;
          target_d    = item_i.reg_addr;
          wr_buf_d    = item_i.write_data;
          read_mode_d = (item_i.cmd == i2cm_pkg::CmdRead);
          if (item_i.cmd == i2cm_pkg::CmdRead) begin
            rd_buf_d = '0;
          end
          byte_idx_d = '0;
          bit_cnt_d  = '0;
          wait_cnt_d = '0;
          ok_d       = 1'b0;
          phase_d    = i2cm_pkg::PhStartB;
        end
      end
      i2cm_pkg::PhStartA: phase_d = i2cm_pkg::PhStartB;
      i2cm_pkg::PhStartB: phase_d = i2cm_pkg::PhStartC;
      i2cm_pkg::PhStartC: begin
        shift_d   = addr_byte;
        bit_cnt_d = '0;
        phase_d   = i2cm_pkg::PhBitLow;
      end
      i2cm_pkg::PhBitLow: phase_d = i2cm_pkg::PhBitHigh;
      i2cm_pkg::PhBitHigh: begin
        shift_d   = {shift_q[6:0], 1'b0};
        bit_cnt_d = bit_inc;
        phase_d   = (bit_inc >= 4'd8) ? i2cm_pkg::PhAckLow : i2cm_pkg::PhBitLow;
      end
      i2cm_pkg::PhAckLow: phase_d = i2cm_pkg::PhAckHigh;
      i2cm_pkg::PhAckHigh: begin
        wait_cnt_d = '0;
        phase_d    = i2cm_pkg::PhAckPoll;
      end
      i2cm_pkg::PhAckPoll: begin
        if (item_i.sda_in) begin
          if (timeout) begin
            ok_d    = 1'b0;
            phase_d = i2cm_pkg::PhStopA;
          end else begin
            wait_cnt_d = wait_cnt_q + 16'd1;
          end
        end else begin
          byte_idx_d = byte_inc;
          if (byte_inc == 4'd1) begin
            shift_d   = target_q;
            bit_cnt_d = '0;
            phase_d   = i2cm_pkg::PhBitLow;
          end else if (!read_mode_q) begin
            if (write_done) begin
              ok_d    = 1'b1;
              phase_d = i2cm_pkg::PhStopA;
            end else begin
              shift_d   = wr_buf_q[{wr_k, 3'b000} +: 8];
              bit_cnt_d = '0;
              phase_d   = i2cm_pkg::PhBitLow;
            end
          end else if (byte_inc == 4'd2) begin
            phase_d = i2cm_pkg::PhStartA;
          end else begin
            byte_idx_d = '0;
            bit_cnt_d  = '0;
            shift_d    = '0;
            phase_d    = i2cm_pkg::PhRdLow;
          end
        end
      end
      i2cm_pkg::PhRdLow: begin
        bit_cnt_d = '0;
        shift_d   = '0;
        phase_d   = i2cm_pkg::PhRdHigh;
      end
      i2cm_pkg::PhRdHigh: phase_d = i2cm_pkg::PhRdSample;
      i2cm_pkg::PhRdSample: begin
        shift_d   = {shift_q[6:0], item_i.sda_in};
        bit_cnt_d = bit_inc;
        phase_d   = (bit_inc >= 4'd8) ? i2cm_pkg::PhMackLow : i2cm_pkg::PhRdHigh;
      end
      i2cm_pkg::PhMackLow: begin
        rd_buf_d[rd_pos +: 8] = shift_q;
        phase_d = i2cm_pkg::PhMackHigh;
      end
      i2cm_pkg::PhMackHigh: phase_d = i2cm_pkg::PhMackEnd;
      i2cm_pkg::PhMackEnd: begin
        if (last_rd) begin
          ok_d    = 1'b1;
          phase_d = i2cm_pkg::PhStopA;
        end else begin
          byte_idx_d = byte_inc;
          phase_d    = i2cm_pkg::PhRdLow;
        end
      end
      i2cm_pkg::PhStopA: phase_d = i2cm_pkg::PhStopB;
      i2cm_pkg::PhStopB: phase_d = i2cm_pkg::PhStopC;
      i2cm_pkg::PhStopC: phase_d = i2cm_pkg::PhIdle;
      default: phase_d = i2cm_pkg::PhIdle;
    endcase
  end

  // bus levels and status for this step
  always_comb begin
    res_o.scl_level = 1'b1;
    res_o.sda_drive = 1'b1;
    res_o.done_res  = 1'b0;
    res_o.success   = 1'b0;
    unique case (phase_q)
      i2cm_pkg::PhStartB: res_o.sda_drive = 1'b0;
      i2cm_pkg::PhStartC, i2cm_pkg::PhStopA: begin
        res_o.scl_level = 1'b0;
        res_o.sda_drive = 1'b0;
      end
      i2cm_pkg::PhBitLow: begin
        res_o.scl_level = 1'b0;
        res_o.sda_drive = shift_q[7];
      end
      i2cm_pkg::PhBitHigh: res_o.sda_drive = shift_q[7];
      i2cm_pkg::PhAckLow, i2cm_pkg::PhRdLow, i2cm_pkg::PhRdSample:
        res_o.scl_level = 1'b0;
      i2cm_pkg::PhAckPoll: res_o.scl_level = item_i.sda_in;
      i2cm_pkg::PhMackLow, i2cm_pkg::PhMackEnd: begin
        res_o.scl_level = 1'b0;
        res_o.sda_drive = last_rd;
      end
      i2cm_pkg::PhMackHigh: res_o.sda_drive = last_rd;
      i2cm_pkg::PhStopB: res_o.sda_drive = 1'b0;
      i2cm_pkg::PhStopC: begin
        res_o.done_res = 1'b1;
        res_o.success  = ok_q;
      end
      default: ;
    endcase
    res_o.busy_res  = (phase_d != i2cm_pkg::PhIdle);
    res_o.read_data = rd_buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cm_pkg::PhIdle;
      bit_cnt_q   <= '0;
      byte_idx_q  <= '0;
      shift_q     <= '0;
      wait_cnt_q  <= '0;
      read_mode_q <= 1'b0;
      ok_q        <= 1'b0;
      total_q     <= '0;
      rd_buf_q    <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_idx_q  <= byte_idx_d;
      shift_q     <= shift_d;
      wait_cnt_q  <= wait_cnt_d;
      read_mode_q <= read_mode_d;
      ok_q        <= ok_d;
      total_q     <= total_d;
      rd_buf_q    <= rd_buf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      wr_buf_q <= wr_buf_d;
      target_q <= target_d;
    end
  end

  a_hold_when_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(byte_idx_q) && $stable(rd_buf_q))
    else $error("state changed without a transfer");

  a_stop_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == i2cm_pkg::PhStopC |=> phase_q == i2cm_pkg::PhIdle)
    else $error("stop sequence did not return to idle");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q <= 4'(i2cm_pkg::MaxBytes + 2))
    else $error("byte index out of range");

  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'd8)
    else $error("bit count out of range");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res && phase_q == i2cm_pkg::PhStopC)
    else $error("done outside of stop completion");

endmodule

// File: hw/rtl/i2c_register_transfer_master_core.sv
// top level of the i2c register transfer master: config registers and result register
// depends on i2cm_pkg and i2cm_engine
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_ready_o / in_item_i): one transfer per bus tick, each
//   tick is one scl half-phase; cmd write or read starts a transaction when idle,
//   otherwise the transfer only advances the sequencer and carries the sampled sda
// - output channel (out_valid_o / out_ready_i / out_item_o): exactly one result per
//   input transfer, giving scl and sda drive, busy, done pulse, success and read bytes
// - config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): index 0 device address,
//   index 1 acknowledge timeout in ticks; write only while no transaction runs
// - output register: the result of a transfer is registered and valid in the cycle after it is accepted
// - throughput: one transfer per cycle, limited by the single result register
// - stall: while a result waits and out_ready_i is low, in_ready_o drops and the
//   sequencer holds; with out_ready_i high a new transfer enters every cycle
// - reset: sequencer idle, read buffer cleared, config back to address 50 and
//   timeout 1000, no result pending

module i2c_register_transfer_master_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  i2cm_pkg::cfg_t      cfg_q;
  i2cm_pkg::out_item_t res;
  i2cm_pkg::out_item_t out_item_q;
  logic                out_valid_q;
  logic                step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= i2cm_pkg::DevAddrReset;
      cfg_q.ack_timeout <= i2cm_pkg::AckTimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cm_pkg::CfgIdxDevAddr:    cfg_q.dev_addr    <= cfg_wdata_i[6:0];
        i2cm_pkg::CfgIdxAckTimeout: cfg_q.ack_timeout <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  i2cm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
